>>> hw/rtl/acs_pkg.sv
// shared constants, configuration codes and item types for the cumulative sum block
package acs_pkg;

  localparam int ELEM_W         = 32;
  localparam int AXIS_LEN_W     = 16;
  localparam int STRIDE_W       = 11;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int DEF_MAX_INNER  = 1024;
  localparam int DEF_VALUE_BITS = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AXIS_LENGTH    = 2'd0,
    CFG_INNER_STRIDE   = 2'd1,
    CFG_EXCLUSIVE_MODE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [ELEM_W-1:0] element_value;
    logic                     tensor_start;
  } in_item_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] sum_value;
    logic                     saturated;
  } out_item_t;

endpackage

>>> hw/rtl/acs_stream_if.sv
// valid/ready stream interface carrying one item of a given payload type
interface acs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input ready, input data);
endinterface

>>> hw/rtl/acs_pos.sv
// configuration registers and axis / inner position counters
module acs_pos import acs_pkg::*; #(
  parameter int MAX_INNER = DEF_MAX_INNER,
  parameter int IW        = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  acc_i,
  input  logic                  start_i,
  output logic [IW-1:0]         addr_o,
  output logic                  first_o,
  output logic                  excl_o
);

  localparam int CW  = $clog2(MAX_INNER + 1);
  localparam int SBW = (CW > STRIDE_W) ? CW : STRIDE_W;
  localparam int LW  = AXIS_LEN_W + 1;

  logic [AXIS_LEN_W-1:0] len_q;
  logic [STRIDE_W-1:0]   stride_q;
  logic                  excl_q;
  logic [IW-1:0]         inner_q, inner_d;
  logic [AXIS_LEN_W-1:0] axis_q, axis_d;

  logic [SBW-1:0]        stride_eff, stride_raw, next_inner;
  logic [LW-1:0]         len_eff, next_axis;
  logic [IW-1:0]         cur_inner, ip;
  logic [AXIS_LEN_W-1:0] cur_axis, ap;
  logic                  wrap;

  always_comb begin
    stride_raw = SBW'(stride_q);
    if (stride_q == '0) begin
      stride_eff = SBW'(1);
    end else if (stride_raw > SBW'(MAX_INNER)) begin
      stride_eff = SBW'(MAX_INNER);
    end else begin
      stride_eff = stride_raw;
    end
    len_eff = (len_q == '0) ? LW'(1) : {1'b0, len_q};

    cur_inner = start_i ? '0 : inner_q;
    cur_axis  = start_i ? '0 : axis_q;
    ip = (SBW'(cur_inner) >= stride_eff) ? '0 : cur_inner;
    ap = ({1'b0, cur_axis} >= len_eff) ? '0 : cur_axis;

    next_inner = SBW'(ip) + SBW'(1);
    next_axis  = {1'b0, ap} + LW'(1);
    wrap       = next_inner >= stride_eff;
    if (wrap) begin
      inner_d = '0;
      axis_d  = (next_axis >= len_eff) ? '0 : next_axis[AXIS_LEN_W-1:0];
    end else begin
      inner_d = next_inner[IW-1:0];
      axis_d  = ap;
    end
  end

  assign addr_o  = ip;
  assign first_o = (ap == '0);
  assign excl_o  = excl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= AXIS_LEN_W'(1);
      stride_q <= STRIDE_W'(1);
      excl_q   <= 1'b0;
      inner_q  <= '0;
      axis_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_AXIS_LENGTH:    len_q    <= cfg_data_i[AXIS_LEN_W-1:0];
          CFG_INNER_STRIDE:   stride_q <= cfg_data_i[STRIDE_W-1:0];
          CFG_EXCLUSIVE_MODE: excl_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (acc_i) begin
        inner_q <= inner_d;
        axis_q  <= axis_d;
      end
    end
  end

endmodule

>>> hw/rtl/acs_ram.sv
// simple dual-port synchronous ram, registered read
module acs_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/acs_update.sv
// read-modify-write stage: forwarding, saturating add and output register
module acs_update import acs_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int IW         = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  acc_i,
  input  logic [IW-1:0]         addr_i,
  input  logic                  first_i,
  input  logic [ELEM_W-1:0]     elem_i,
  input  logic                  excl_i,
  input  logic [VALUE_BITS-1:0] rdata_i,
  output logic                  in_ready_o,
  output logic                  wr_en_o,
  output logic [IW-1:0]         wr_addr_o,
  output logic [VALUE_BITS-1:0] wr_data_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o
);

  localparam int SW = ((VALUE_BITS > ELEM_W) ? VALUE_BITS : ELEM_W) + 1;
  localparam logic [SW-1:0] MAXV = {{(SW-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
  localparam logic [SW-1:0] MINV = {{(SW-VALUE_BITS+1){1'b1}}, {(VALUE_BITS-1){1'b0}}};

  logic                  s1_valid_q;
  logic [IW-1:0]         s1_addr_q;
  logic                  s1_first_q;
  logic [ELEM_W-1:0]     s1_elem_q;
  logic                  byp_valid_q;
  logic [IW-1:0]         byp_addr_q;
  logic [VALUE_BITS-1:0] byp_data_q;
  logic                  out_valid_q;
  out_item_t             out_data_q;

  logic                  adv, move, hi, lo;
  logic [VALUE_BITS-1:0] old, old_w, sum, emit;
  logic [SW-1:0]         x_ext, old_ext, raw, emit_ext;

  assign adv        = !out_valid_q || out_ready_i;
  assign move       = s1_valid_q && adv;
  assign in_ready_o = !s1_valid_q || adv;

  always_comb begin
    // last write wins over the ram when it hit the same entry
    old   = (byp_valid_q && (byp_addr_q == s1_addr_q)) ? byp_data_q : rdata_i;
    old_w = s1_first_q ? '0 : old;
    x_ext   = {{(SW-ELEM_W){s1_elem_q[ELEM_W-1]}}, s1_elem_q};
    old_ext = {{(SW-VALUE_BITS){old[VALUE_BITS-1]}}, old};
    raw     = s1_first_q ? x_ext : (old_ext + x_ext);
    hi = $signed(raw) > $signed(MAXV);
    lo = $signed(raw) < $signed(MINV);
    if (hi) begin
      sum = MAXV[VALUE_BITS-1:0];
    end else if (lo) begin
      sum = MINV[VALUE_BITS-1:0];
    end else begin
      sum = raw[VALUE_BITS-1:0];
    end
    emit     = excl_i ? old_w : sum;
    emit_ext = {{(SW-VALUE_BITS){emit[VALUE_BITS-1]}}, emit};
  end

  assign wr_en_o   = move;
  assign wr_addr_o = s1_addr_q;
  assign wr_data_o = sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      byp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc_i) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (move) begin
        byp_valid_q <= 1'b1;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_addr_q  <= addr_i;
      s1_first_q <= first_i;
      s1_elem_q  <= elem_i;
    end
    if (move) begin
      byp_addr_q           <= s1_addr_q;
      byp_data_q           <= sum;
      out_data_q.sum_value <= emit_ext[ELEM_W-1:0];
      out_data_q.saturated <= hi || lo;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> hw/rtl/axis_cumulative_sum.sv
// an accepted item is registered in the update stage, then its result in the output register
// throughput: one item per cycle unless out_o stalls; a partial sum read-add-write per item
// the partial sum ram has one read and one write port; same-entry hazards are forwarded
// reset: asynchronous active low, clears counters, pipeline valids and configuration
// configuration resets to axis length 1, stride 1, inclusive; partial sums need no clearing
module axis_cumulative_sum import acs_pkg::*; #(
  parameter int MAX_INNER  = DEF_MAX_INNER,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  acs_stream_if.sink            in_i,
  acs_stream_if.source          out_o
);

  // index width of the partial sum store
  localparam int IW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;

  logic                  acc;
  logic                  in_ready;
  logic [IW-1:0]         rd_addr;
  logic                  first;
  logic                  excl;
  logic [VALUE_BITS-1:0] rdata;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [VALUE_BITS-1:0] wr_data;
  logic                  out_valid;
  out_item_t             out_data;

  // an item enters whenever the update stage is free or emptying this cycle
  assign acc         = in_i.valid && in_ready;
  assign in_i.ready  = in_ready;

  // position counters pick the entry; the read is launched as the item is taken
  acs_pos #(
    .MAX_INNER (MAX_INNER),
    .IW        (IW)
  ) u_pos (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .acc_i      (acc),
    .start_i    (in_i.data.tensor_start),
    .addr_o     (rd_addr),
    .first_o    (first),
    .excl_o     (excl)
  );

  // one partial sum per inner position
  acs_ram #(
    .DEPTH (MAX_INNER),
    .WIDTH (VALUE_BITS),
    .AW    (IW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (acc),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // add, clamp, write back and hold the result until taken
  acs_update #(
    .VALUE_BITS (VALUE_BITS),
    .IW         (IW)
  ) u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .addr_i      (rd_addr),
    .first_i     (first),
    .elem_i      (in_i.data.element_value),
    .excl_i      (excl),
    .rdata_i     (rdata),
    .in_ready_o  (in_ready),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

endmodule

>>> hw/rtl/acs_checker.sv
// port-level checks for the cumulative sum block and their binding
module acs_checker (
  input logic          clk_i,
  input logic          rst_ni,
  acs_stream_if.sink   in_i,
  acs_stream_if.source out_i
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_i.valid && !out_i.ready |=> out_i.valid && $stable(out_i.data))
    else $error("result changed while stalled");

  // input is only refused when a result is waiting and blocked
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_i.valid && !out_i.ready)
    else $error("input refused without output back-pressure");

  // a taken item is followed by a valid result or a ready input
  a_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> out_i.valid || in_i.ready)
    else $error("item lost in pipeline");

  // a fresh result needs an item taken before it and passed through the update stage register
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_i.valid) |-> $past(in_i.valid && in_i.ready, 2))
    else $error("result without an item");

endmodule

bind axis_cumulative_sum acs_checker u_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_i  (out_o)
);
